// ----- rtl/core/rptg_pkg.sv -----
// Shared types, constants and helper functions for the pulse train generator.
package rptg_pkg;

  localparam int TIMER_BITS = 24;
  localparam int WIDTH_BITS = 16;
  localparam int GAP_BITS = 16;
  localparam int PERIOD_BITS = 24;
  localparam int COUNT_BITS = 8;
  localparam int MULT_BITS = 8;
  localparam int PROD_BITS = WIDTH_BITS + MULT_BITS;
  localparam int LIMIT_BITS = (PROD_BITS > PERIOD_BITS) ? PROD_BITS : PERIOD_BITS;
  localparam int CMP_BITS = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef logic [TIMER_BITS-1:0] timer_t;
  localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_STOP  = 3'd0,
    PH_START = 3'd1,
    PH_ON    = 3'd2,
    PH_OFF   = 3'd3,
    PH_IDLE  = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PULSE_WIDTH   = 3'd0,
    REG_PULSE_GAP     = 3'd1,
    REG_REPEAT_PERIOD = 3'd2,
    REG_ACTIVE_HIGH   = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  pulse_width_ms;
    logic [GAP_BITS-1:0]    pulse_gap_ms;
    logic [PERIOD_BITS-1:0] repeat_period_ms;
    logic                   active_high;
  } rptg_cfg_t;

  typedef struct packed {
    logic                  action;
    logic [COUNT_BITS-1:0] pulse_count;
    logic [MULT_BITS-1:0]  width_multiplier;
    logic                  repeat_mode;
  } rptg_item_t;

  typedef struct packed {
    logic                  pin_level;
    logic [2:0]            phase;
    logic [COUNT_BITS-1:0] pulses_left;
  } rptg_result_t;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_CMD  = 1'b1;

  // True once the timer has reached the limit, limit clamped to timer range.
  function automatic logic reached(input timer_t elapsed, input logic [LIMIT_BITS-1:0] limit);
    logic [CMP_BITS-1:0] lim;
    logic [CMP_BITS-1:0] tmax;
    tmax = CMP_BITS'(TIMER_MAX);
    lim = CMP_BITS'(limit);
    if (lim > tmax) lim = tmax;
    return CMP_BITS'(elapsed) >= lim;
  endfunction

  function automatic timer_t sat_inc(input timer_t t);
    return (t == TIMER_MAX) ? t : t + TIMER_BITS'(1);
  endfunction

endpackage

// ----- rtl/core/rptg_if.sv -----
// Valid/ready channel interfaces for items, results and register writes.
interface rptg_in_if
  import rptg_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COUNT_BITS-1:0] pulse_count;
  logic [MULT_BITS-1:0]  width_multiplier;
  logic                  repeat_mode;

  modport source (output valid, action, pulse_count, width_multiplier, repeat_mode,
                  input ready);
  modport sink (input valid, action, pulse_count, width_multiplier, repeat_mode,
                output ready);
endinterface

interface rptg_out_if
  import rptg_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  pin_level;
  logic [2:0]            phase;
  logic [COUNT_BITS-1:0] pulses_left;

  modport source (output valid, pin_level, phase, pulses_left, input ready);
  modport sink (input valid, pin_level, phase, pulses_left, output ready);
endinterface

interface rptg_cfg_if
  import rptg_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/rptg_cfg_regs.sv -----
// Configuration register bank with write decode.
module rptg_cfg_regs
  import rptg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  output rptg_cfg_t                cfg
);

  rptg_cfg_t cfg_r;
  rptg_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_PULSE_WIDTH:   cfg_nxt.pulse_width_ms = wr_data[WIDTH_BITS-1:0];
        REG_PULSE_GAP:     cfg_nxt.pulse_gap_ms = wr_data[GAP_BITS-1:0];
        REG_REPEAT_PERIOD: cfg_nxt.repeat_period_ms = wr_data[PERIOD_BITS-1:0];
        REG_ACTIVE_HIGH:   cfg_nxt.active_high = wr_data[0];
        default:           cfg_nxt = cfg_r;  // drop writes beyond the bank
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_width_ms <= WIDTH_BITS'(100);
      cfg_r.pulse_gap_ms <= GAP_BITS'(100);
      cfg_r.repeat_period_ms <= PERIOD_BITS'(1000);
      cfg_r.active_high <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/rptg_step.sv -----
// Burst state registers and the per-transaction phase step.
module rptg_step
  import rptg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  rptg_item_t   item,
  input  rptg_cfg_t    cfg,
  output rptg_result_t result_nxt
);

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] burst_r, burst_nxt;
  logic [COUNT_BITS-1:0] cd_r, cd_nxt;
  logic [MULT_BITS-1:0]  mult_r, mult_nxt;
  logic                  rep_r, rep_nxt;
  timer_t                pe_r, pe_nxt;
  timer_t                be_r, be_nxt;
  logic                  pin_r, pin_nxt;

  logic [PROD_BITS-1:0]  on_lim;
  logic [PROD_BITS-1:0]  off_lim;
  logic                  on_lvl;
  logic                  off_lvl;
  timer_t                pe_inc;
  timer_t                be_inc;

  assign on_lim  = PROD_BITS'(cfg.pulse_width_ms) * PROD_BITS'(mult_r);
  assign off_lim = PROD_BITS'(cfg.pulse_gap_ms) * PROD_BITS'(mult_r);
  assign on_lvl  = cfg.active_high;
  assign off_lvl = ~cfg.active_high;
  assign pe_inc  = sat_inc(pe_r);
  assign be_inc  = sat_inc(be_r);

  always_comb begin
    phase_nxt = phase_r;
    burst_nxt = burst_r;
    cd_nxt    = cd_r;
    mult_nxt  = mult_r;
    rep_nxt   = rep_r;
    pe_nxt    = pe_r;
    be_nxt    = be_r;
    pin_nxt   = pin_r;
    if (step_en) begin
      if (item.action == ACT_CMD) begin
        if (item.pulse_count != '0) begin
          phase_nxt = PH_START;
          burst_nxt = item.pulse_count;
          mult_nxt  = (item.width_multiplier != '0) ? item.width_multiplier
                                                    : MULT_BITS'(1);
          rep_nxt   = item.repeat_mode;
        end else begin
          phase_nxt = PH_STOP;
          pin_nxt   = off_lvl;
        end
      end else begin
        pe_nxt = pe_inc;
        be_nxt = be_inc;
        unique case (phase_r)
          PH_START: begin
            phase_nxt = PH_ON;
            cd_nxt    = burst_r;
            pe_nxt    = '0;
            be_nxt    = '0;
            pin_nxt   = on_lvl;
          end
          PH_ON: begin
            if (reached(pe_inc, LIMIT_BITS'(on_lim))) begin
              if (cd_r != '0) cd_nxt = cd_r - COUNT_BITS'(1);
              phase_nxt = PH_OFF;
              pe_nxt    = '0;
              pin_nxt   = off_lvl;
            end
          end
          PH_OFF: begin
            if (reached(pe_inc, LIMIT_BITS'(off_lim))) begin
              if (cd_r != '0) begin
                phase_nxt = PH_ON;
                pe_nxt    = '0;
                pin_nxt   = on_lvl;
              end else if (rep_r) begin
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
          end
          PH_IDLE: begin
            if (reached(be_inc, LIMIT_BITS'(cfg.repeat_period_ms))) begin
              phase_nxt = PH_ON;
              cd_nxt    = burst_r;
              pe_nxt    = '0;
              be_nxt    = '0;
              pin_nxt   = on_lvl;
            end
          end
          default: phase_nxt = phase_r;  // stopped: timers only
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STOP;
      burst_r <= '0;
      cd_r    <= '0;
      mult_r  <= MULT_BITS'(1);
      rep_r   <= 1'b0;
      pe_r    <= '0;
      be_r    <= '0;
      pin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      burst_r <= burst_nxt;
      cd_r    <= cd_nxt;
      mult_r  <= mult_nxt;
      rep_r   <= rep_nxt;
      pe_r    <= pe_nxt;
      be_r    <= be_nxt;
      pin_r   <= pin_nxt;
    end
  end

  assign result_nxt.pin_level   = pin_nxt;
  assign result_nxt.phase       = phase_nxt;
  assign result_nxt.pulses_left = cd_nxt;

  a_stop_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.action == ACT_CMD && item.pulse_count == '0
    |=> phase_r == PH_STOP)
    else $error("stop command did not stop the burst");

  a_start_to_on: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.action == ACT_TICK && phase_r == PH_START
    |=> phase_r == PH_ON && pe_r == '0 && be_r == '0 && cd_r == $past(burst_r))
    else $error("start did not load the burst");

  a_timer_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.action == ACT_TICK
    |=> pe_r == '0 || pe_r == TIMER_MAX || pe_r == $past(pe_r) + TIMER_BITS'(1))
    else $error("pulse timer stepped wrongly");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(pe_r) && $stable(cd_r) && $stable(pin_r))
    else $error("state moved without a transaction");

  a_mult_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mult_r != '0)
    else $error("multiplier register is zero");

endmodule

// ----- rtl/core/repeating_pulse_train_generator_unit.sv -----
// Top level: input register, phase step, result register and config bank.
// Pipeline: two stages, input register and result register; an accepted
//   transaction moves into the result register, setting out valid, whenever
//   that register is free or drains. Throughput: one per cycle unless stalled;
//   the two 16x8 multiplies, timer compare and phase select are combinational.
// Reset: synchronous active-low rst_n clears both stage valid flags, the burst
//   state and timers, and loads the register defaults; no clearing pass.
module repeating_pulse_train_generator_unit
  import rptg_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  rptg_in_if.sink        in_if,
  rptg_out_if.source     out_if,
  rptg_cfg_if.sink       cfg_if
);

  rptg_cfg_t    cfg;
  rptg_item_t   item_r, item_nxt;
  logic         in_vld_r, in_vld_nxt;
  rptg_result_t res_r, res_nxt;
  rptg_result_t step_res;
  logic         out_vld_r, out_vld_nxt;
  logic         in_acc;
  logic         adv;
  logic         step_en;

  // Register writes are always taken.
  assign cfg_if.ready = 1'b1;

  rptg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  // Advance the input stage whenever the result register is free or drains.
  assign adv         = !out_vld_r || out_if.ready;
  assign step_en     = in_vld_r && adv;
  assign in_if.ready = !in_vld_r || adv;
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    item_nxt   = item_r;
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      item_nxt.action           = in_if.action;
      item_nxt.pulse_count      = in_if.pulse_count;
      item_nxt.width_multiplier = in_if.width_multiplier;
      item_nxt.repeat_mode      = in_if.repeat_mode;
      in_vld_nxt                = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;  // drop the consumed transaction
    end
  end

  rptg_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .item       (item_r),
    .cfg        (cfg),
    .result_nxt (step_res)
  );

  // Hold the result until taken; load a fresh one on each step.
  always_comb begin
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (step_en) begin
      res_nxt     = step_res;
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.pin_level   = res_r.pin_level;
  assign out_if.phase       = res_r.phase;
  assign out_if.pulses_left = res_r.pulses_left;

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_if.ready |=> out_vld_r && $stable(res_r))
    else $error("result changed while stalled");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_vld_r)
    else $error("step produced no result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(item_r))
    else $error("input stage lost a pending transaction");

endmodule
